// File: design/emd_pkg.sv
// ----------------------------------------------------------------------------
// emd_pkg: shared types and codes for the embedding match core
// Holds the beat structs, sizes, opcodes, event, identity and announce codes and register indexes.
// ----------------------------------------------------------------------------
package emd_pkg;

  localparam int EMBED_DIM = 128;
  localparam int NUM_PROFILES = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_NOFACE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] EV_REG = 2'd0;
  localparam logic [1:0] EV_QUERY = 2'd1;
  localparam logic [1:0] EV_NOFACE = 2'd2;

  localparam logic [1:0] ID_UNKNOWN = 2'd0;
  localparam logic [1:0] ID_GUEST = 2'd1;
  localparam logic [1:0] ID_USER = 2'd2;

  localparam logic [1:0] AN_NONE = 2'd0;
  localparam logic [1:0] AN_USER = 2'd1;
  localparam logic [1:0] AN_GUEST = 2'd2;
  localparam logic [1:0] AN_REG = 2'd3;

  localparam logic [1:0] CFG_THRESH = 2'd0;
  localparam logic [1:0] CFG_ULIM = 2'd1;
  localparam logic [1:0] CFG_GLIM = 2'd2;

  localparam int SCORE_W = 40;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] slot;
    logic [6:0] element_index;
    logic signed [15:0] element_value;
    logic last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic matched;
    logic [3:0] matched_slot;
    logic signed [39:0] top_score;
    logic [1:0] stable_kind;
    logic [3:0] stable_slot;
    logic [1:0] announce;
  } out_beat_t;

endpackage

// File: design/emd_ram.sv
// ----------------------------------------------------------------------------
// emd_ram: generic single-port RAM
// One address per cycle: an optional write and a registered read of the old contents.
// ----------------------------------------------------------------------------
module emd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/emd_front.sv
// ----------------------------------------------------------------------------
// emd_front: input classifier and command queue
// Drops beats that have no effect and queues the rest for the back end.
// ----------------------------------------------------------------------------
module emd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  emd_pkg::in_beat_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output emd_pkg::in_beat_t q_data
);
  import emd_pkg::*;

  localparam int QD = 4;

  in_beat_t   q_r [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       keep;
  logic       push;

  // Write beats to absent slots and unused opcodes are dropped here.
  always_comb begin
    keep = 1'b0;
    case (in_data.opcode)
      OP_WRITE:  keep = ({1'b0, in_data.slot} < 5'(NUM_PROFILES));
      OP_QUERY:  keep = 1'b1;
      OP_NOFACE: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == 3'(QD));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 3'd0);
  assign q_data   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (q_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(q_pop);
    end
  end
endmodule

// File: design/emd_back.sv
// ----------------------------------------------------------------------------
// emd_back: profile store, shared MAC and identity debouncer
// Walks one slot per cycle through a single multiply-accumulate.
// ----------------------------------------------------------------------------
module emd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  emd_pkg::in_beat_t  q_data,
  input  logic signed [15:0] thresh,
  input  logic [7:0]         ulim,
  input  logic [7:0]         glim,
  output logic               out_valid,
  input  logic               out_stall,
  output emd_pkg::out_beat_t out_data
);
  import emd_pkg::*;

  localparam int SW = (NUM_PROFILES > 1) ? $clog2(NUM_PROFILES) : 1;
  localparam int IW = $clog2(EMBED_DIM);
  localparam int AW = SW + IW;
  localparam int DEPTH = NUM_PROFILES * EMBED_DIM;
  localparam logic signed [SCORE_W-1:0] SMAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SMIN = {1'b1, {(SCORE_W-1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_DEB  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] st_r;
  in_beat_t   cmd_r;
  logic [SW:0] sc_r;          // slot counter for issuing reads
  logic [SW:0] ac_r;          // slot counter for accumulation
  logic        rd_v_r;
  logic [SW-1:0] rd_s_r;
  logic signed [31:0] prod_r;
  logic        prod_v_r;
  logic [SW-1:0] prod_s_r;
  logic signed [SCORE_W-1:0] sums_r [NUM_PROFILES];
  logic [NUM_PROFILES-1:0] pvalid_r;
  logic [1:0] kind_r;
  logic [3:0] islot_r;
  logic [7:0] absent_r, stranger_r;
  logic       m_r;
  logic [SW-1:0] win_r;
  logic signed [SCORE_W-1:0] best_r;
  out_beat_t  res_r;          // finished result waiting for the output register
  out_beat_t  ob_r;
  logic       ov_r;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rd;
  logic          idx_ok;
  logic signed [SCORE_W:0] tsum;
  logic signed [SCORE_W-1:0] tsat;

  assign idx_ok = ({1'b0, cmd_r.element_index} < 8'(EMBED_DIM));
  assign ram_we = (st_r == ST_MAC) && (cmd_r.opcode == OP_WRITE) && idx_ok;
  always_comb begin
    if (cmd_r.opcode == OP_WRITE) begin
      ram_addr = {cmd_r.slot[SW-1:0], cmd_r.element_index[IW-1:0]};
    end else begin
      ram_addr = {sc_r[SW-1:0], cmd_r.element_index[IW-1:0]};
    end
  end

  emd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata(cmd_r.element_value), .rdata(ram_rd)
  );

  assign tsum = {sums_r[prod_s_r][SCORE_W-1], sums_r[prod_s_r]} + (SCORE_W+1)'(prod_r);
  always_comb begin
    if (tsum > (SCORE_W+1)'(SMAX)) tsat = SMAX;
    else if (tsum < (SCORE_W+1)'(SMIN)) tsat = SMIN;
    else tsat = tsum[SCORE_W-1:0];
  end

  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_data;
    rd_s_r   <= sc_r[SW-1:0];
    prod_r   <= cmd_r.element_value * $signed(ram_rd);
    prod_s_r <= rd_s_r;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      pvalid_r <= '0;
      kind_r <= ID_UNKNOWN;
      islot_r <= '0;
      absent_r <= '0;
      stranger_r <= '0;
      rd_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      sc_r <= '0;
      ac_r <= '0;
      for (int i = 0; i < NUM_PROFILES; i++) sums_r[i] <= '0;
    end else begin
      // The output register loads only when empty or being taken this cycle.
      if (st_r == ST_OUT && (!ov_r || !out_stall)) begin
        ov_r <= 1'b1;
        ob_r <= res_r;
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
      rd_v_r   <= 1'b0;
      prod_v_r <= rd_v_r;
      if (prod_v_r) begin
        sums_r[prod_s_r] <= tsat;
        ac_r <= ac_r + 1'b1;
      end
      case (st_r)
        ST_IDLE: begin
          if (q_pop) begin
            st_r <= ST_MAC;
            sc_r <= '0;
            ac_r <= '0;
          end
        end
        ST_MAC: begin
          if (cmd_r.opcode == OP_WRITE) begin
            if (cmd_r.last) begin
              pvalid_r[cmd_r.slot[SW-1:0]] <= 1'b1;
              kind_r <= ID_USER;
              islot_r <= cmd_r.slot;
              res_r <= '{EV_REG, 1'b0, 4'd0, '0, ID_USER, cmd_r.slot, AN_REG};
              st_r <= ST_OUT;
            end else begin
              st_r <= ST_IDLE;
            end
          end else if (cmd_r.opcode == OP_NOFACE) begin
            st_r <= ST_DEB;
          end else if (!idx_ok) begin
            st_r <= cmd_r.last ? ST_SEL : ST_IDLE;
            sc_r <= '0;
          end else begin
            if (sc_r < (SW+1)'(NUM_PROFILES)) begin
              rd_v_r <= 1'b1;
              sc_r <= sc_r + 1'b1;
            end
            if (ac_r == (SW+1)'(NUM_PROFILES)) begin
              st_r <= cmd_r.last ? ST_SEL : ST_IDLE;
              sc_r <= '0;
            end
          end
          m_r <= 1'b0;
          win_r <= '0;
          best_r <= SCORE_W'(thresh) <<< 15;
        end
        ST_SEL: begin
          // one slot per cycle; strict compare keeps the lowest on ties
          if (pvalid_r[sc_r[SW-1:0]] && sums_r[sc_r[SW-1:0]] > best_r) begin
            best_r <= sums_r[sc_r[SW-1:0]];
            win_r <= sc_r[SW-1:0];
            m_r <= 1'b1;
          end
          sums_r[sc_r[SW-1:0]] <= '0;
          sc_r <= sc_r + 1'b1;
          if (sc_r == (SW+1)'(NUM_PROFILES - 1)) st_r <= ST_DEB;
        end
        ST_DEB: begin
          if (cmd_r.opcode == OP_NOFACE) begin
            stranger_r <= '0;
            if (absent_r != 8'hFF) absent_r <= absent_r + 8'd1;
            if (((absent_r == 8'hFF) ? 8'hFF : absent_r + 8'd1) >= ulim) begin
              kind_r <= ID_UNKNOWN;
              islot_r <= '0;
              res_r <= '{EV_NOFACE, 1'b0, 4'd0, '0, ID_UNKNOWN, 4'd0, AN_NONE};
            end else begin
              res_r <= '{EV_NOFACE, 1'b0, 4'd0, '0, kind_r, islot_r, AN_NONE};
            end
          end else begin
            absent_r <= '0;
            if (m_r) begin
              stranger_r <= '0;
              kind_r <= ID_USER;
              islot_r <= 4'(win_r);
              res_r <= '{EV_QUERY, 1'b1, 4'(win_r), best_r, ID_USER, 4'(win_r),
                         (kind_r == ID_USER && islot_r == 4'(win_r)) ? AN_NONE : AN_USER};
            end else if (((stranger_r == 8'hFF) ? 8'hFF : stranger_r + 8'd1) >= glim
                         && kind_r != ID_GUEST) begin
              stranger_r <= '0;
              kind_r <= ID_GUEST;
              islot_r <= '0;
              res_r <= '{EV_QUERY, 1'b0, 4'd0, best_r, ID_GUEST, 4'd0, AN_GUEST};
            end else begin
              if (stranger_r != 8'hFF) stranger_r <= stranger_r + 8'd1;
              res_r <= '{EV_QUERY, 1'b0, 4'd0, best_r, kind_r, islot_r, AN_NONE};
            end
          end
          st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!ov_r || !out_stall) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: design/embedding_match_with_identity_debounce_core.sv
// ----------------------------------------------------------------------------
// embedding_match_with_identity_debounce_core: face profile matcher
// Dot-product matching against stored profiles with a streak debouncer.
// ----------------------------------------------------------------------------
// Usage: input beats arrive on in_valid/in_stall/in_data. A profile write
// beat stores one Q1.15 element; the beat marked last registers the slot and
// produces one result beat. A query beat is multiplied into every slot's
// running score through one shared multiply-accumulate that walks the slots
// one per cycle, set by that single MAC and the one read port of the profile
// memory. The last query beat adds a selection pass over every slot and then
// yields a match result. A no-face beat goes straight to the debouncer and
// yields a result.
// A small command queue in front keeps taking beats while the back end is
// busy, so in_stall rises only when that queue is full.
// Results leave on out_valid/out_stall/out_data from a held output register;
// while the receiver stalls, the back end finishes its beat and waits.
// Reset is synchronous on rst_n; it clears valid slots, scores, streaks and
// the identity, and restores the register defaults. Profile memory contents
// are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
module embedding_match_with_identity_debounce_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  emd_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output emd_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import emd_pkg::*;

  logic signed [15:0] thresh_r;
  logic [7:0]         ulim_r, glim_r;
  logic               q_valid, q_pop;
  in_beat_t           q_data;

  // Configuration registers, to be written by the user only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 16'sd13107;
      ulim_r   <= 8'd30;
      glim_r   <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESH: thresh_r <= cfg_wdata;
        CFG_ULIM:   ulim_r   <= cfg_wdata[7:0];
        CFG_GLIM:   glim_r   <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  emd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  emd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_data(q_data), .thresh(thresh_r), .ulim(ulim_r), .glim(glim_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // A held result must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // A match result always names the known user it matched.
  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.matched |->
      out_data.stable_kind == ID_USER && out_data.stable_slot == out_data.matched_slot)
    else $error("match without matching identity");

  // Registration results announce a registration.
  a_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_REG |-> out_data.announce == AN_REG)
    else $error("registration without announce");
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the embedding match core
// Streams profile writes, queries and no-face frames under random idling,
// predicts every result beat in a scoreboard and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
  import emd_pkg::*;

  localparam int DIM = 128;
  localparam int SLOTS = 16;
  localparam longint SCORE_HI = 64'sd549755813887;
  localparam longint SCORE_LO = -64'sd549755813888;
  localparam int CYCLE_LIMIT = 2000000;

  // Scoreboard: carries its own copy of the profile table, running scores,
  // identity and streak counters, and queues the result beat that an
  // accepted input beat must produce, if it produces one.
  class emd_scoreboard;
    shortint   store [SLOTS][DIM];
    bit        valid [SLOTS];
    longint    sums [SLOTS];
    logic [1:0] id_kind;
    logic [3:0] id_slot;
    int        absent_run;
    int        stranger_run;
    int        threshold;
    int        unknown_lim;
    int        guest_lim;
    out_beat_t pending[$];
    int        errors;

    function void reset_state();
      foreach (store[s, i]) store[s][i] = 0;
      foreach (valid[s]) begin
        valid[s] = 0;
        sums[s] = 0;
      end
      id_kind = ID_UNKNOWN;
      id_slot = 0;
      absent_run = 0;
      stranger_run = 0;
      threshold = 13107;
      unknown_lim = 30;
      guest_lim = 5;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_THRESH: threshold = int'($signed(data));
        CFG_ULIM: unknown_lim = int'(data[7:0]);
        CFG_GLIM: guest_lim = int'(data[7:0]);
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] ev, bit m, logic [3:0] ms, longint score,
                       logic [1:0] an);
      out_beat_t r;
      r.event_kind = ev;
      r.matched = m;
      r.matched_slot = ms;
      r.top_score = score[39:0];
      r.stable_kind = id_kind;
      r.stable_slot = id_slot;
      r.announce = an;
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(in_beat_t b);
      longint t;
      longint best;
      bit m;
      logic [3:0] win;
      logic [1:0] an;
      case (b.opcode)
        OP_WRITE: begin
          store[b.slot][b.element_index] = shortint'(b.element_value);
          if (b.last) begin
            valid[b.slot] = 1;
            id_kind = ID_USER;
            id_slot = b.slot;
            push(EV_REG, 1'b0, 4'd0, 0, AN_REG);
          end
        end
        OP_QUERY: begin
          for (int s = 0; s < SLOTS; s++) begin
            t = sums[s] + longint'(shortint'(b.element_value)) *
                longint'(store[s][b.element_index]);
            if (t > SCORE_HI) t = SCORE_HI;
            if (t < SCORE_LO) t = SCORE_LO;
            sums[s] = t;
          end
          if (b.last) begin
            best = longint'(threshold) * 32768;
            m = 0;
            win = 0;
            an = AN_NONE;
            // Strictly greater keeps the lowest slot on a tie.
            for (int s = 0; s < SLOTS; s++) begin
              if (valid[s] && sums[s] > best) begin
                best = sums[s];
                win = s[3:0];
                m = 1;
              end
            end
            foreach (sums[s]) sums[s] = 0;
            absent_run = 0;
            if (m) begin
              stranger_run = 0;
              if (!(id_kind == ID_USER && id_slot == win)) begin
                id_kind = ID_USER;
                id_slot = win;
                an = AN_USER;
              end
            end else begin
              if (stranger_run < 255) stranger_run++;
              if (stranger_run >= guest_lim && id_kind != ID_GUEST) begin
                id_kind = ID_GUEST;
                id_slot = 0;
                stranger_run = 0;
                an = AN_GUEST;
              end
            end
            push(EV_QUERY, m, m ? win : 4'd0, best, an);
          end
        end
        OP_NOFACE: begin
          stranger_run = 0;
          if (absent_run < 255) absent_run++;
          if (absent_run >= unknown_lim) begin
            id_kind = ID_UNKNOWN;
            id_slot = 0;
          end
          push(EV_NOFACE, 1'b0, 4'd0, 0, AN_NONE);
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", r);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("event_kind", e.event_kind, r.event_kind);
      cmp("matched", e.matched, r.matched);
      cmp("matched_slot", e.matched_slot, r.matched_slot);
      cmp("top_score", e.top_score, r.top_score);
      cmp("stable_kind", e.stable_kind, r.stable_kind);
      cmp("stable_slot", e.stable_slot, r.stable_slot);
      cmp("announce", e.announce, r.announce);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  emd_scoreboard sb = new();

  // Which table entries the bench has written; a query only touches indexes
  // that every registered slot holds, so no registered slot reads an undefined entry.
  bit  written [SLOTS][DIM];
  bit  idle_on;
  bit  hold_req;
  int  cycles;
  int  beats_sent;

  embedding_match_with_identity_debounce_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Results are taken at the rising edge where the beat is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver side: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 30);
        out_stall <= 0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Offers one beat, holding it until the block takes it, with an optional
  // sender gap first.
  task automatic send_beat(logic [1:0] op, logic [3:0] slot, int idx,
                           logic [15:0] val, bit lst);
    in_beat_t b;
    int n;
    b.opcode = op;
    b.slot = slot;
    b.element_index = idx[6:0];
    b.element_value = val;
    b.last = lst;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    if (op == OP_WRITE) written[slot][idx] = 1;
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid <= 0;
  endtask

  // Picks an index that all registered slots have written.
  function automatic int pick_idx();
    int ok[$];
    bit good;
    for (int i = 0; i < DIM; i++) begin
      good = 1;
      for (int s = 0; s < SLOTS; s++)
        if (sb.valid[s] && !written[s][i]) good = 0;
      if (good) ok.insert(ok.size(), i);
    end
    if (ok.size() == 0) return 0;
    return ok[$urandom_range(0, ok.size() - 1)];
  endfunction

  // Writes a profile over indexes 0..len-1 and registers it.
  task automatic register_slot(logic [3:0] slot, int len, bit fixed,
                               logic [15:0] v);
    for (int i = 0; i < len; i++)
      send_beat(OP_WRITE, slot, i, fixed ? v : 16'($urandom), i == len - 1);
  endtask

  // A query of len beats; in copy mode it replays one slot's profile so a
  // match is likely.
  task automatic run_query(int len, int target, bit copy);
    int idx;
    for (int k = 0; k < len; k++) begin
      idx = pick_idx();
      send_beat(OP_QUERY, 4'($urandom), idx,
                copy ? 16'(sb.store[target][idx]) : 16'($urandom),
                k == len - 1);
    end
  endtask

  // Registers change only with the block drained and quiet.
  task automatic set_regs(logic [15:0] th, logic [7:0] ul, logic [7:0] gl);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    for (int r = 0; r < 3; r++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= (r == 0) ? CFG_THRESH : (r == 1) ? CFG_ULIM : CFG_GLIM;
      cfg_wdata <= (r == 0) ? th : (r == 1) ? {8'd0, ul} : {8'd0, gl};
      @(posedge clk);
      sb.set_reg((r == 0) ? CFG_THRESH : (r == 1) ? CFG_ULIM : CFG_GLIM,
                 (r == 0) ? th : (r == 1) ? {8'd0, ul} : {8'd0, gl});
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Mixed random traffic; mostly whole registrations and queries.
  task automatic random_traffic(int count);
    int goal;
    int r;
    int tgt;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      r = $urandom_range(0, 99);
      tgt = $urandom_range(0, SLOTS - 1);
      if (r < 15) begin
        register_slot(4'(tgt), $urandom_range(8, 12), 1'b0, 16'd0);
      end else if (r < 55) begin
        run_query($urandom_range(1, 12), tgt, 1'($urandom_range(0, 1)));
      end else if (r < 72) begin
        repeat ($urandom_range(1, 40)) send_beat(OP_NOFACE, 4'($urandom),
                                                 $urandom_range(0, DIM - 1),
                                                 16'($urandom), 1'($urandom));
      end else if (r < 84) begin
        // A stray element write without a last mark.
        send_beat(OP_WRITE, 4'(tgt), $urandom_range(0, DIM - 1),
                  16'($urandom), 1'b0);
      end else if (r < 90) begin
        send_beat(OP_UNUSED, 4'($urandom), $urandom_range(0, DIM - 1),
                  16'($urandom), 1'($urandom));
      end else begin
        run_query(1, tgt, 1'b0);
      end
    end
    stop_sending();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_THRESH;
    cfg_wdata = 0;
    idle_on = 1;
    hold_req = 0;
    cycles = 0;
    beats_sent = 0;
    sb.reset_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extreme element values, a registration ending on the top
    // index, a replayed query, no-face frames and the unused opcode.
    send_beat(OP_WRITE, 4'd0, 0, 16'h7fff, 1'b0);
    send_beat(OP_WRITE, 4'd0, 1, 16'h8000, 1'b0);
    send_beat(OP_WRITE, 4'd0, 2, 16'h0000, 1'b0);
    send_beat(OP_WRITE, 4'd0, 3, 16'h5555, 1'b0);
    send_beat(OP_WRITE, 4'd0, 4, 16'haaaa, 1'b1);
    send_beat(OP_WRITE, 4'd15, 0, 16'h0001, 1'b0);
    send_beat(OP_WRITE, 4'd15, 1, 16'hffff, 1'b0);
    send_beat(OP_WRITE, 4'd15, 2, 16'h2000, 1'b0);
    send_beat(OP_WRITE, 4'd15, 3, 16'h1000, 1'b0);
    send_beat(OP_WRITE, 4'd15, 4, 16'h0800, 1'b0);
    send_beat(OP_WRITE, 4'd15, 127, 16'h0400, 1'b1);
    run_query(5, 0, 1'b1);
    send_beat(OP_QUERY, 4'd0, 0, 16'h0000, 1'b1);
    send_beat(OP_NOFACE, 4'd0, 0, 16'h0000, 1'b0);
    send_beat(OP_NOFACE, 4'hf, 127, 16'hffff, 1'b1);
    send_beat(OP_UNUSED, 4'ha, 85, 16'h1234, 1'b1);
    send_beat(OP_QUERY, 4'd0, 2, 16'h8000, 1'b1);
    stop_sending();

    // Lowest threshold and limits of one: most queries match, and every
    // stranger or absence flips the identity at once.
    set_regs(16'h8000, 8'd1, 8'd1);
    random_traffic(60);

    // Top threshold and limits: matches become rare, the absence counter is
    // driven into saturation and the stranger streak runs up to its limit.
    set_regs(16'h7fff, 8'd255, 8'd255);
    repeat (260) send_beat(OP_NOFACE, 4'd0, 0, 16'h0000, 1'b0);
    repeat (260) run_query(1, 0, 1'b0);
    stop_sending();
    random_traffic(40);

    // Zero limits are met immediately.
    set_regs(16'h0000, 8'd0, 8'd0);
    random_traffic(50);

    // Long receiver hold-off while the sender keeps pushing beats.
    set_regs(16'($urandom), 8'($urandom_range(1, 10)), 8'($urandom_range(1, 10)));
    hold_req = 1;
    random_traffic(80);

    // Score saturation in both directions in one query: a slot full of +1.0
    // runs to the negative bound and a slot full of -1.0 to the positive one.
    set_regs(16'd13107, 8'($urandom_range(1, 40)), 8'($urandom_range(1, 8)));
    register_slot(4'd14, 8, 1'b1, 16'h7fff);
    register_slot(4'd15, 8, 1'b1, 16'h8000);
    for (int k = 0; k < 520; k++) send_beat(OP_QUERY, 4'd0, 0, 16'h8000, k == 519);
    stop_sending();
    random_traffic(60);

    set_regs(16'($urandom_range(0, 20000)), 8'($urandom_range(1, 20)),
             8'($urandom_range(1, 6)));
    random_traffic(50);

    // Closing stretch runs at full rate on both sides.
    set_regs(16'($urandom), 8'($urandom), 8'($urandom));
    idle_on = 0;
    random_traffic(90);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: embedding_match_with_identity_debounce_core.f
design/emd_pkg.sv
design/emd_ram.sv
design/emd_front.sv
design/emd_back.sv
design/embedding_match_with_identity_debounce_core.sv
tb/tb.sv
